// ===== rtl/ftprp_pkg.sv =====
// Package for the FTP control reply parser.
// Holds the parser phase enum, state and result structs, character codes and the port digit
// helper; no dependencies.
package ftprp_pkg;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam int CODE_DIGITS = 3;
    localparam int PART_DIGITS = 3;
    localparam int PASV_COMMAS = 4;
    localparam logic [11:0] PART_MAX = 12'd255;

    typedef enum logic [2:0] {
        PH_CODE   = 3'd0,
        PH_WAITNL = 3'd1,
        PH_CONT   = 3'd2,
        PH_PAREN  = 3'd3,
        PH_COMMAS = 3'd4,
        PH_HIGH   = 3'd5,
        PH_LOW    = 3'd6
    } phase_t;

    typedef struct packed {
        phase_t          phase;
        logic [1:0]      digit_count;
        logic [2:0][3:0] code_digits;
        logic [1:0]      match_count;
        logic [2:0]      comma_count;
        logic [7:0]      high_part;
        logic [7:0]      low_part;
        logic [1:0]      high_digits;
        logic [1:0]      low_digits;
        logic            high_ended;
        logic            low_ended;
        logic            overflow_seen;
    } state_t;

    localparam state_t STATE_CLEAR = '0;

    typedef struct packed {
        logic [9:0]  reply_code;
        logic [3:0]  reply_class;
        logic [15:0] data_port;
        logic        port_overflow;
    } result_t;

    typedef struct packed {
        logic [7:0] val;
        logic [1:0] ndig;
        logic       ended;
        logic       ovf;
    } part_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Advance one port part by one character; ovf reports saturation.
    function automatic part_t port_char(logic [7:0] c, part_t p);
        part_t      r;
        logic [11:0] v;
        r     = p;
        r.ovf = 1'b0;
        v     = ({4'b0, p.val} * 12'd10) + {8'b0, c[3:0]};
        if (!p.ended) begin
            if (is_digit(c)) begin
                if (p.ndig != 2'(PART_DIGITS)) begin
                    if (v > PART_MAX) begin
                        r.val = PART_MAX[7:0];
                        r.ovf = 1'b1;
                    end else begin
                        r.val = v[7:0];
                    end
                    r.ndig = p.ndig + 2'd1;
                end
            end else if (!(is_blank(c) && (p.ndig == 2'd0))) begin
                r.ended = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/ftp_reply_parser_unit.sv =====
// Top level of the FTP control reply parser: handshakes, parser state and result register.
// Depends on ftprp_pkg and ftprp_step.
//
// Takes one reply character per cycle on the s_ channel while s_ready is high and gives one
// transfer on the m_ channel when a reply completes (newline in normal mode, closing
// parenthesis in passive mode), carrying the reply code, its class and, in passive mode,
// the data port and a saturation flag. Each character is handled by the combinational state
// update logic and registered into the parser state; the result sits in an output register,
// so s_ready stays high while that register is empty or being taken. cfg_passive_mode is
// written through its own channel, always ready, and must only change between replies.
module ftp_reply_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_passive_mode,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_reply_code,
    output logic [3:0]  m_reply_class,
    output logic [15:0] m_data_port,
    output logic        m_port_overflow
);

    logic                passive_reg;
    ftprp_pkg::state_t   state_reg;
    ftprp_pkg::state_t   state_next;
    logic                emit;
    ftprp_pkg::result_t  res_next;
    ftprp_pkg::result_t  res_reg;
    logic                m_valid_reg;
    logic                accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    ftprp_step u_step (
        .cur          (state_reg),
        .rx_byte      (s_rx_byte),
        .passive_mode (passive_reg),
        .nxt          (state_next),
        .emit         (emit),
        .res          (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            passive_reg <= 1'b0;
            state_reg   <= ftprp_pkg::STATE_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                passive_reg <= cfg_passive_mode;
            end
            if (accept && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_reply_code    = res_reg.reply_code;
    assign m_reply_class   = res_reg.reply_class;
    assign m_data_port     = res_reg.data_port;
    assign m_port_overflow = res_reg.port_overflow;

endmodule

// ===== rtl/ftprp_step.sv =====
// Next-state and result logic for one received character of the reply parser.
// Depends on ftprp_pkg.
module ftprp_step (
    input  ftprp_pkg::state_t  cur,
    input  logic [7:0]         rx_byte,
    input  logic               passive_mode,
    output ftprp_pkg::state_t  nxt,
    output logic               emit,
    output ftprp_pkg::result_t res
);

    logic             digit;
    logic [3:0]       dval;
    ftprp_pkg::part_t part_in;
    ftprp_pkg::part_t part_out;
    logic [9:0]       code;

    assign digit = ftprp_pkg::is_digit(rx_byte);
    assign dval  = rx_byte[3:0];
    assign code  = ({6'b0, cur.code_digits[0]} * 10'd100)
                 + ({6'b0, cur.code_digits[1]} * 10'd10)
                 + {6'b0, cur.code_digits[2]};

    always_comb begin
        if (cur.phase == ftprp_pkg::PH_HIGH) begin
            part_in = '{val: cur.high_part, ndig: cur.high_digits,
                        ended: cur.high_ended, ovf: 1'b0};
        end else begin
            part_in = '{val: cur.low_part, ndig: cur.low_digits,
                        ended: cur.low_ended, ovf: 1'b0};
        end
        part_out = ftprp_pkg::port_char(rx_byte, part_in);
    end

    always_comb begin
        nxt  = cur;
        emit = 1'b0;
        res  = '{reply_code: code, reply_class: cur.code_digits[0],
                 data_port: 16'd0, port_overflow: 1'b0};
        unique case (cur.phase)
            ftprp_pkg::PH_CODE: begin
                if (digit) begin
                    if (cur.digit_count != 2'(ftprp_pkg::CODE_DIGITS)) begin
                        nxt.code_digits[cur.digit_count] = dval;
                        nxt.digit_count = cur.digit_count + 2'd1;
                    end
                end else if (rx_byte == ftprp_pkg::CH_SPACE &&
                             cur.digit_count == 2'(ftprp_pkg::CODE_DIGITS)) begin
                    nxt.phase = passive_mode ? ftprp_pkg::PH_PAREN : ftprp_pkg::PH_WAITNL;
                end else if (rx_byte == ftprp_pkg::CH_DASH && !passive_mode &&
                             cur.digit_count == 2'(ftprp_pkg::CODE_DIGITS)) begin
                    nxt.phase = ftprp_pkg::PH_CONT;
                end
            end
            ftprp_pkg::PH_WAITNL: begin
                if (rx_byte == ftprp_pkg::CH_LF) begin
                    emit = 1'b1;
                    nxt  = ftprp_pkg::STATE_CLEAR;
                end
            end
            ftprp_pkg::PH_CONT: begin
                if (digit) begin
                    if (cur.match_count != 2'(ftprp_pkg::CODE_DIGITS) &&
                        cur.code_digits[cur.match_count] == dval) begin
                        nxt.match_count = cur.match_count + 2'd1;
                    end
                end else if (rx_byte == ftprp_pkg::CH_SPACE) begin
                    if (cur.match_count == 2'(ftprp_pkg::CODE_DIGITS)) begin
                        nxt.phase = ftprp_pkg::PH_WAITNL;
                    end
                end else if (rx_byte == ftprp_pkg::CH_DASH) begin
                    nxt.match_count = 2'd0;
                end
            end
            ftprp_pkg::PH_PAREN: begin
                if (rx_byte == ftprp_pkg::CH_LPAREN) begin
                    nxt.phase = ftprp_pkg::PH_COMMAS;
                end
            end
            ftprp_pkg::PH_COMMAS: begin
                if (rx_byte == ftprp_pkg::CH_COMMA) begin
                    nxt.comma_count = cur.comma_count + 3'd1;
                    if (cur.comma_count + 3'd1 >= 3'(ftprp_pkg::PASV_COMMAS)) begin
                        nxt.phase = ftprp_pkg::PH_HIGH;
                    end
                end
            end
            ftprp_pkg::PH_HIGH: begin
                if (rx_byte == ftprp_pkg::CH_COMMA) begin
                    nxt.phase = ftprp_pkg::PH_LOW;
                end else begin
                    nxt.high_part     = part_out.val;
                    nxt.high_digits   = part_out.ndig;
                    nxt.high_ended    = part_out.ended;
                    nxt.overflow_seen = cur.overflow_seen | part_out.ovf;
                end
            end
            ftprp_pkg::PH_LOW: begin
                if (rx_byte == ftprp_pkg::CH_RPAREN) begin
                    emit              = 1'b1;
                    res.data_port     = {cur.high_part, cur.low_part};
                    res.port_overflow = cur.overflow_seen;
                    nxt               = ftprp_pkg::STATE_CLEAR;
                end else if (rx_byte != ftprp_pkg::CH_COMMA) begin
                    nxt.low_part      = part_out.val;
                    nxt.low_digits    = part_out.ndig;
                    nxt.low_ended     = part_out.ended;
                    nxt.overflow_seen = cur.overflow_seen | part_out.ovf;
                end
            end
            default: begin
                nxt = ftprp_pkg::STATE_CLEAR;
            end
        endcase
    end

endmodule

// ===== tb/ftp_reply_parser_unit_tb.sv =====
// Self-checking bench for ftp_reply_parser_unit: directed replies, then random normal and
// passive replies mixed with noise under random stalls on both channels.
// Depends on ftprp_pkg and the RTL of ftp_reply_parser_unit.
module ftp_reply_parser_unit_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 18;
    localparam int CALM_FROM   = 700;
    localparam int CALM_TO     = 1000;
    localparam int PHASE_ITEMS = 190;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_passive_mode;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [9:0]  m_reply_code;
    logic [3:0]  m_reply_class;
    logic [15:0] m_data_port;
    logic        m_port_overflow;

    ftp_reply_parser_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_passive_mode(cfg_passive_mode),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_reply_code    (m_reply_code),
        .m_reply_class   (m_reply_class),
        .m_data_port     (m_data_port),
        .m_port_overflow (m_port_overflow)
    );

    logic              mode_pasv;
    ftprp_pkg::phase_t ps_phase;
    int                code_n;
    int                match_n;
    int                comma_n;
    logic [3:0]        code_d [3];
    logic [7:0]        part_val [2];
    int                part_n [2];
    bit                part_end [2];
    bit                part_sat;

    ftprp_pkg::result_t reply_q[$];
    logic [7:0]         pending_q[$];
    logic [7:0]         frame_q[$];
    int                 items_pushed;
    int                 items_taken;
    int                 cfg_writes;
    int                 errors;
    int                 cycles;
    bit                 in_taken;

    function automatic bit digit_char(logic [7:0] c);
        return c >= ftprp_pkg::CH_ZERO && c <= ftprp_pkg::CH_NINE;
    endfunction

    function automatic bit blank_char(logic [7:0] c);
        return c == ftprp_pkg::CH_SPACE || (c >= ftprp_pkg::CH_TAB && c <= ftprp_pkg::CH_CR);
    endfunction

    task automatic clear_parse;
        ps_phase = ftprp_pkg::PH_CODE;
        code_n   = 0;
        match_n  = 0;
        comma_n  = 0;
        part_sat = 0;
        for (int i = 0; i < 3; i++) code_d[i] = '0;
        for (int k = 0; k < 2; k++) begin
            part_val[k] = '0;
            part_n[k]   = 0;
            part_end[k] = 0;
        end
    endtask

    task automatic feed_part(int k, logic [7:0] c);
        int v;
        if (!part_end[k]) begin
            if (digit_char(c)) begin
                if (part_n[k] < ftprp_pkg::PART_DIGITS) begin
                    v = int'(part_val[k]) * 10 + int'(c - ftprp_pkg::CH_ZERO);
                    if (v > 255) begin
                        v        = 255;
                        part_sat = 1;
                    end
                    part_val[k] = v[7:0];
                    part_n[k]++;
                end
            end else if (!(blank_char(c) && part_n[k] == 0)) begin
                part_end[k] = 1;
            end
        end
    endtask

    task automatic emit_reply(bit with_port);
        ftprp_pkg::result_t r;
        r.reply_code    = 10'(int'(code_d[0]) * 100 + int'(code_d[1]) * 10 + int'(code_d[2]));
        r.reply_class   = code_d[0];
        r.data_port     = with_port ? {part_val[0], part_val[1]} : 16'd0;
        r.port_overflow = with_port ? part_sat : 1'b0;
        reply_q.push_back(r);
        clear_parse();
    endtask

    task automatic parse_byte(logic [7:0] c);
        case (ps_phase)
            ftprp_pkg::PH_CODE: begin
                if (digit_char(c)) begin
                    if (code_n < ftprp_pkg::CODE_DIGITS) begin
                        code_d[code_n] = 4'(c - ftprp_pkg::CH_ZERO);
                        code_n++;
                    end
                end else if (c == ftprp_pkg::CH_SPACE && code_n == ftprp_pkg::CODE_DIGITS) begin
                    ps_phase = mode_pasv ? ftprp_pkg::PH_PAREN : ftprp_pkg::PH_WAITNL;
                end else if (c == ftprp_pkg::CH_DASH && code_n == ftprp_pkg::CODE_DIGITS &&
                             !mode_pasv) begin
                    ps_phase = ftprp_pkg::PH_CONT;
                end
            end
            ftprp_pkg::PH_WAITNL: begin
                if (c == ftprp_pkg::CH_LF) emit_reply(0);
            end
            ftprp_pkg::PH_CONT: begin
                if (digit_char(c)) begin
                    if (match_n < ftprp_pkg::CODE_DIGITS &&
                        code_d[match_n] == 4'(c - ftprp_pkg::CH_ZERO)) match_n++;
                end else if (c == ftprp_pkg::CH_SPACE) begin
                    if (match_n == ftprp_pkg::CODE_DIGITS) ps_phase = ftprp_pkg::PH_WAITNL;
                end else if (c == ftprp_pkg::CH_DASH) begin
                    match_n = 0;
                end
            end
            ftprp_pkg::PH_PAREN: begin
                if (c == ftprp_pkg::CH_LPAREN) ps_phase = ftprp_pkg::PH_COMMAS;
            end
            ftprp_pkg::PH_COMMAS: begin
                if (c == ftprp_pkg::CH_COMMA) begin
                    comma_n++;
                    if (comma_n >= ftprp_pkg::PASV_COMMAS) ps_phase = ftprp_pkg::PH_HIGH;
                end
            end
            ftprp_pkg::PH_HIGH: begin
                if (c == ftprp_pkg::CH_COMMA) ps_phase = ftprp_pkg::PH_LOW;
                else feed_part(0, c);
            end
            ftprp_pkg::PH_LOW: begin
                if (c == ftprp_pkg::CH_RPAREN) emit_reply(1);
                else if (c != ftprp_pkg::CH_COMMA) feed_part(1, c);
            end
            default: begin
                clear_parse();
            end
        endcase
    endtask

    // byte that moves the parser toward the end of the reply in progress
    function automatic logic [7:0] closing_byte;
        case (ps_phase)
            ftprp_pkg::PH_CODE:
                return code_n < ftprp_pkg::CODE_DIGITS ? ftprp_pkg::CH_ZERO
                                                       : ftprp_pkg::CH_SPACE;
            ftprp_pkg::PH_WAITNL: return ftprp_pkg::CH_LF;
            ftprp_pkg::PH_CONT:
                return match_n < ftprp_pkg::CODE_DIGITS
                       ? 8'(ftprp_pkg::CH_ZERO + code_d[match_n]) : ftprp_pkg::CH_SPACE;
            ftprp_pkg::PH_PAREN:  return ftprp_pkg::CH_LPAREN;
            ftprp_pkg::PH_COMMAS: return ftprp_pkg::CH_COMMA;
            ftprp_pkg::PH_HIGH:   return ftprp_pkg::CH_COMMA;
            default:              return ftprp_pkg::CH_RPAREN;
        endcase
    endfunction

    function automatic bit idle_now;
        if (cycles >= CALM_FROM && cycles < CALM_TO) return 0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    task automatic push_byte(logic [7:0] b);
        pending_q.push_back(b);
        items_pushed++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic add_byte(logic [7:0] b);
        frame_q.push_back(b);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_junk(int n, bit letters_only);
        for (int i = 0; i < n; i++) begin
            if (letters_only) add_byte(8'($urandom_range(8'h7A, 8'h61)));
            else add_byte(8'($urandom_range(8'h7E, 8'h20)));
        end
    endtask

    task automatic add_eol;
        if ($urandom_range(3) != 0) add_byte(ftprp_pkg::CH_CR);
        add_byte(ftprp_pkg::CH_LF);
    endtask

    task automatic build_plain;
        int code;
        int lines;
        code = $urandom_range(999);
        if ($urandom_range(2) == 0) begin
            lines = $urandom_range(2);
            add_text($sformatf("%03d-", code));
            add_junk($urandom_range(6), 1);
            add_eol();
            for (int i = 0; i < lines; i++) begin
                if ($urandom_range(1)) add_text($sformatf("%03d-", code));
                else add_byte(ftprp_pkg::CH_SPACE);
                add_junk($urandom_range(6), 1);
                add_eol();
            end
            add_text($sformatf("%03d ", code));
            add_junk($urandom_range(6), 1);
        end else begin
            add_text($sformatf("%03d ", code));
            add_junk($urandom_range(8), 0);
        end
        add_eol();
    endtask

    task automatic add_part;
        int r;
        r = $urandom_range(99);
        if (r < 10) add_byte($urandom_range(1) ? ftprp_pkg::CH_SPACE : ftprp_pkg::CH_TAB);
        else if (r < 15) add_byte($urandom_range(1) ? ftprp_pkg::CH_DASH : 8'h2B);
        r = $urandom_range(99);
        if (r >= 5) begin
            if (r < 70) add_text($sformatf("%0d", $urandom_range(255)));
            else if (r < 88) add_text($sformatf("%0d", $urandom_range(999, 256)));
            else add_text($sformatf("%0d", $urandom_range(999999, 1000)));
        end
        if ($urandom_range(99) < 8) add_text(" 7");
    endtask

    task automatic build_pasv;
        add_text($sformatf("%03d ", $urandom_range(999)));
        add_junk($urandom_range(8), 1);
        add_byte(ftprp_pkg::CH_LPAREN);
        for (int i = 0; i < ftprp_pkg::PASV_COMMAS; i++) begin
            add_text($sformatf("%0d", $urandom_range(255)));
            add_byte(ftprp_pkg::CH_COMMA);
        end
        add_part();
        add_byte(ftprp_pkg::CH_COMMA);
        add_part();
        add_byte(ftprp_pkg::CH_RPAREN);
        add_eol();
    endtask

    task automatic random_run(int count);
        int upto;
        int r;
        upto = items_pushed + count;
        while (items_pushed < upto) begin
            frame_q.delete();
            r = $urandom_range(99);
            if (r < 86) begin
                if ((r < 78) == mode_pasv) build_pasv();
                else build_plain();
            end else if (r < 94) begin
                repeat ($urandom_range(6, 1)) add_byte(8'($urandom_range(255)));
            end else begin
                if (mode_pasv) build_pasv();
                else build_plain();
                frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom_range(255));
            end
            foreach (frame_q[i]) push_byte(frame_q[i]);
        end
    endtask

    // drain the input, finish any open reply, collect all results
    task automatic settle;
        wait (items_taken == items_pushed);
        while (!(ps_phase == ftprp_pkg::PH_CODE && code_n == 0)) begin
            push_byte(closing_byte());
            wait (items_taken == items_pushed);
        end
        wait (reply_q.size() == 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_mode(bit pasv);
        int n;
        settle();
        n = cfg_writes;
        @(negedge aclk);
        cfg_valid        <= 1'b1;
        cfg_passive_mode <= pasv;
        wait (cfg_writes == n + 1);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin : monitor
        ftprp_pkg::result_t want;
        cycles++;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    $error("reply transfer with none pending: reply_code %0d", m_reply_code);
                    errors++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_reply_code !== want.reply_code) begin
                        $error("reply_code expected %0d got %0d", want.reply_code, m_reply_code);
                        errors++;
                    end
                    if (m_reply_class !== want.reply_class) begin
                        $error("reply_class expected %0d got %0d", want.reply_class,
                               m_reply_class);
                        errors++;
                    end
                    if (m_data_port !== want.data_port) begin
                        $error("data_port expected %0d got %0d", want.data_port, m_data_port);
                        errors++;
                    end
                    if (m_port_overflow !== want.port_overflow) begin
                        $error("port_overflow expected %0d got %0d", want.port_overflow,
                               m_port_overflow);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                mode_pasv = cfg_passive_mode;
                cfg_writes++;
            end
            if (s_valid && s_ready) begin
                parse_byte(s_rx_byte);
                in_taken = 1;
                items_taken++;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                in_taken = 0;
                if (pending_q.size() != 0 && !idle_now()) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= pending_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !idle_now();
        end
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_passive_mode = 1'b0;
        s_valid          = 1'b0;
        s_rx_byte        = 8'h00;
        m_ready          = 1'b0;
        items_pushed     = 0;
        items_taken      = 0;
        cfg_writes       = 0;
        errors           = 0;
        cycles           = 0;
        in_taken         = 0;
        mode_pasv        = 1'b0;
        clear_parse();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_mode(0);
        push_byte(8'hFF);
        push_text("x1-2345 ");
        push_byte(8'h00);
        push_text("\n");
        push_text("999-9x8-99 9 \n");
        set_mode(1);
        push_text("227- ab(,,,,  2999,+5 ,7)");
        push_byte(ftprp_pkg::CH_CR);
        push_text("\n150 (9,9,9,9,\t0,255)");

        set_mode(1);
        random_run(PHASE_ITEMS);
        set_mode(0);
        random_run(PHASE_ITEMS);
        set_mode(1);
        random_run(PHASE_ITEMS);
        set_mode(0);
        random_run(PHASE_ITEMS);
        set_mode(0);
        random_run(PHASE_ITEMS);
        set_mode(1);
        random_run(PHASE_ITEMS);

        settle();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ftprp_pkg.sv
rtl/ftprp_step.sv
rtl/ftp_reply_parser_unit.sv
tb/ftp_reply_parser_unit_tb.sv
